// ===== rtl/core/wave_chunk_parser_core_assert.svh =====
// Assertion helpers for the WAVE chunk parser checker.
// The enclosing module must declare clk_i and rst_ni.
`ifndef WAVE_CHUNK_PARSER_CORE_ASSERT_SVH
`define WAVE_CHUNK_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WCP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wave chunk parser: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wave chunk parser: next-cycle check failed");

`endif

// ===== rtl/core/wcp_pkg.sv =====
`default_nettype none

package wcp_pkg;

  // Four-character tags, first byte in the top byte
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Largest length a skipped chunk may carry
  localparam logic [31:0] SIZE_LIMIT = 32'h7fff_ffff;

  // Bytes of the fmt chunk that are parsed
  localparam logic [31:0] FMT_BYTES = 32'd14;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_NOT_RIFF    = 3'd1,
    ERR_NOT_WAVE    = 3'd2,
    ERR_MISSING     = 3'd3,
    ERR_SIZE        = 3'd4,
    ERR_FMT_SHORT   = 3'd5,
    ERR_UNSUPPORTED = 3'd6
  } err_code_e;

  typedef enum logic [2:0] {
    PH_FILE = 3'd0,
    PH_HEAD = 3'd1,
    PH_SKIP = 3'd2,
    PH_FMT  = 3'd3,
    PH_DATA = 3'd4,
    PH_IDLE = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic               is_error;
    logic [2:0]         error_code;
    logic signed [15:0] sample;
    logic [31:0]        sample_rate;
    logic               last_sample;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/wcp_if.sv =====
`default_nettype none

// Byte stream into the parser
interface wcp_in_if;
  logic              valid;
  logic              ready;
  wcp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result stream out of the parser
interface wcp_out_if;
  logic               valid;
  logic               ready;
  wcp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wave_chunk_parser_core.sv =====
// Channel   Dir  Payload                                            Transfer
// in_i      in   file_byte[7:0], end_of_file                       valid & ready
// out_o     out  is_error, error_code[2:0], sample[15:0] (Q15),    valid & ready
//                sample_rate[31:0], last_sample
//
// One byte per cycle while in_i.ready is high: each byte updates the parser
// state when taken, and its result (if any) is registered on the output.
// A result register plus one skid register sit on the output; in_i.ready
// drops only while the skid register holds a result.
// rst_ni (async, active low) returns the parser to the file header phase and
// empties the output; the byte carrying end_of_file does the same for the
// parser state after its result is formed.
`default_nettype none

module wave_chunk_parser_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wcp_in_if.sink     in_i,
  wcp_out_if.source  out_o
);

  // Parser state
  wcp_pkg::phase_e phase_q, phase_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     tag_q, tag_d;
  logic [31:0]     len_q, len_d;
  logic            fmt_seen_q, fmt_seen_d;
  logic [15:0]     chan_q, chan_d;
  logic [7:0]      align_lo_q, align_lo_d;
  logic [31:0]     rate_q, rate_d;
  logic [7:0]      low_q, low_d;

  // Output stage
  logic               out_valid_q, skid_valid_q;
  wcp_pkg::out_item_t out_q, skid_q;

  // Per-byte work signals
  logic               in_fire, out_fire;
  logic [7:0]         b;
  logic               eof;
  logic [31:0]        tag_new;
  logic [31:0]        pos_inc;
  logic [31:0]        len_even;
  logic [31:0]        len_head;
  logic [31:0]        len_fmt_left;
  logic [15:0]        align_new;
  logic               res_valid;
  wcp_pkg::out_item_t res;

  function automatic wcp_pkg::out_item_t err_item(wcp_pkg::err_code_e code);
    wcp_pkg::out_item_t r;
    r            = '0;
    r.is_error   = 1'b1;
    r.error_code = code;
    return r;
  endfunction

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign b        = in_i.payload.file_byte;
  assign eof      = in_i.payload.end_of_file;

  // Arithmetic used by the phases
  assign tag_new      = {tag_q[23:0], b};
  assign pos_inc      = pos_q + 32'd1;
  assign len_even     = {len_q[31:1], 1'b0};
  assign len_head     = {b, len_q[23:0]};
  assign len_fmt_left = len_q - wcp_pkg::FMT_BYTES;
  assign align_new    = {b, align_lo_q};

  // Next state and result for one byte
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tag_d      = tag_q;
    len_d      = len_q;
    fmt_seen_d = fmt_seen_q;
    chan_d     = chan_q;
    align_lo_d = align_lo_q;
    rate_d     = rate_q;
    low_d      = low_q;
    res_valid  = 1'b0;
    res        = '0;

    if (in_fire) begin
      unique case (phase_q)
        wcp_pkg::PH_FILE: begin
          tag_d = tag_new;
          if (pos_q == 32'd3 && tag_new != wcp_pkg::TAG_RIFF) begin
            res_valid = 1'b1;
            res       = err_item(wcp_pkg::ERR_NOT_RIFF);
            phase_d   = wcp_pkg::PH_IDLE;
          end else if (pos_q == 32'd11) begin
            if (eof) begin
              res_valid = 1'b1;
              res       = err_item(wcp_pkg::ERR_NOT_RIFF);
              phase_d   = wcp_pkg::PH_IDLE;
            end else if (tag_new != wcp_pkg::TAG_WAVE) begin
              res_valid = 1'b1;
              res       = err_item(wcp_pkg::ERR_NOT_WAVE);
              phase_d   = wcp_pkg::PH_IDLE;
            end else begin
              phase_d = wcp_pkg::PH_HEAD;
              pos_d   = '0;
              len_d   = '0;
            end
          end else begin
            pos_d = pos_inc;
            if (eof) begin
              res_valid = 1'b1;
              res       = err_item(wcp_pkg::ERR_NOT_RIFF);
              phase_d   = wcp_pkg::PH_IDLE;
            end
          end
        end

        wcp_pkg::PH_HEAD: begin
          // tag bytes then little-endian length bytes
          if (!pos_q[2]) begin
            tag_d = tag_new;
            if (pos_q[1:0] == 2'd0) begin
              len_d = '0;
            end
          end else begin
            case (pos_q[1:0])
              2'd0:    len_d[7:0]   = b;
              2'd1:    len_d[15:8]  = b;
              2'd2:    len_d[23:16] = b;
              default: len_d[31:24] = b;
            endcase
          end

          if (pos_q[2:0] != 3'd7) begin
            pos_d = pos_inc;
            if (eof) begin
              res_valid = 1'b1;
              res       = err_item(wcp_pkg::ERR_MISSING);
              phase_d   = wcp_pkg::PH_IDLE;
            end
          end else if (tag_q == wcp_pkg::TAG_FMT && !fmt_seen_q) begin
            if (len_head < wcp_pkg::FMT_BYTES || eof) begin
              res_valid = 1'b1;
              res       = err_item(wcp_pkg::ERR_FMT_SHORT);
              phase_d   = wcp_pkg::PH_IDLE;
            end else begin
              phase_d = wcp_pkg::PH_FMT;
              pos_d   = '0;
            end
          end else if (tag_q == wcp_pkg::TAG_DATA && fmt_seen_q) begin
            pos_d   = '0;
            phase_d = (len_head == '0) ? wcp_pkg::PH_IDLE : wcp_pkg::PH_DATA;
          end else if (len_head > wcp_pkg::SIZE_LIMIT) begin
            res_valid = 1'b1;
            res       = err_item(wcp_pkg::ERR_SIZE);
            phase_d   = wcp_pkg::PH_IDLE;
          end else if (eof) begin
            res_valid = 1'b1;
            res       = err_item(wcp_pkg::ERR_MISSING);
            phase_d   = wcp_pkg::PH_IDLE;
          end else begin
            pos_d   = '0;
            phase_d = (len_head == '0) ? wcp_pkg::PH_HEAD : wcp_pkg::PH_SKIP;
          end
        end

        wcp_pkg::PH_SKIP: begin
          if (pos_inc >= len_q) begin
            phase_d = wcp_pkg::PH_HEAD;
            pos_d   = '0;
          end else begin
            pos_d = pos_inc;
          end
          if (eof) begin
            res_valid = 1'b1;
            res       = err_item(wcp_pkg::ERR_MISSING);
            phase_d   = wcp_pkg::PH_IDLE;
          end
        end

        wcp_pkg::PH_FMT: begin
          // capture channels, rate and block align
          case (pos_q[3:0])
            4'd2:    chan_d[7:0]    = b;
            4'd3:    chan_d[15:8]   = b;
            4'd4:    rate_d         = {24'd0, b};
            4'd5:    rate_d[15:8]   = b;
            4'd6:    rate_d[23:16]  = b;
            4'd7:    rate_d[31:24]  = b;
            4'd12:   align_lo_d     = b;
            default: ;
          endcase

          if (pos_q[3:0] != 4'd13) begin
            pos_d = pos_inc;
            if (eof) begin
              res_valid = 1'b1;
              res       = err_item(wcp_pkg::ERR_FMT_SHORT);
              phase_d   = wcp_pkg::PH_IDLE;
            end
          end else if (chan_q != 16'd1 || align_new != 16'd2) begin
            res_valid = 1'b1;
            res       = err_item(wcp_pkg::ERR_UNSUPPORTED);
            phase_d   = wcp_pkg::PH_IDLE;
          end else begin
            fmt_seen_d = 1'b1;
            len_d      = len_fmt_left;
            if (eof) begin
              res_valid = 1'b1;
              res       = err_item(wcp_pkg::ERR_MISSING);
              phase_d   = wcp_pkg::PH_IDLE;
            end else begin
              pos_d   = '0;
              phase_d = (len_fmt_left == '0) ? wcp_pkg::PH_HEAD : wcp_pkg::PH_SKIP;
            end
          end
        end

        wcp_pkg::PH_DATA: begin
          // even byte: low half; odd byte: complete sample unless unpaired
          if (!pos_q[0]) begin
            low_d = b;
          end else if (pos_q < len_even) begin
            res_valid       = 1'b1;
            res.sample      = {b, low_q};
            res.sample_rate = rate_q;
            res.last_sample = (pos_inc == len_even);
          end
          pos_d = pos_inc;
          if (pos_inc >= len_q) begin
            phase_d = wcp_pkg::PH_IDLE;
          end
        end

        wcp_pkg::PH_IDLE: ;

        default: phase_d = wcp_pkg::PH_IDLE;
      endcase

      // end of file: back to the reset state for the next file
      if (eof) begin
        phase_d    = wcp_pkg::PH_FILE;
        pos_d      = '0;
        tag_d      = '0;
        len_d      = '0;
        fmt_seen_d = 1'b0;
        chan_d     = '0;
        align_lo_d = '0;
        rate_d     = '0;
        low_d      = '0;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wcp_pkg::PH_FILE;
      pos_q      <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      fmt_seen_q <= 1'b0;
      chan_q     <= '0;
      align_lo_q <= '0;
      rate_q     <= '0;
      low_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      fmt_seen_q <= fmt_seen_d;
      chan_q     <= chan_d;
      align_lo_q <= align_lo_d;
      rate_q     <= rate_d;
      low_q      <= low_d;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_i.ready    = !skid_valid_q;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/wcp_checker.sv =====
`default_nettype none

`include "wave_chunk_parser_core_assert.svh"

module wcp_sva_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        is_error_i,
  input wire logic [2:0]  error_code_i,
  input wire logic [15:0] sample_i,
  input wire logic [31:0] sample_rate_i,
  input wire logic        last_sample_i
);

  // a pending result stays offered until taken
  `WCP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // backpressure on the input only while a result is waiting, and one drain clears it
  `WCP_ASSERT_SAME(a_stall_has_result, !in_ready_i, out_valid_i)
  `WCP_ASSERT_NEXT(a_stall_one_cycle, !in_ready_i && out_ready_i, in_ready_i)

  // error reports carry a code and nothing else
  `WCP_ASSERT_SAME(a_err_fields, out_valid_i && is_error_i,
                   error_code_i != wcp_pkg::ERR_NONE && sample_i == 16'd0 &&
                   sample_rate_i == 32'd0 && !last_sample_i)

  // samples carry no error code
  `WCP_ASSERT_SAME(a_sample_code, out_valid_i && !is_error_i,
                   error_code_i == wcp_pkg::ERR_NONE)

endmodule

bind wave_chunk_parser_core wcp_sva_checker u_wcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .is_error_i    (out_o.payload.is_error),
  .error_code_i  (out_o.payload.error_code),
  .sample_i      (out_o.payload.sample),
  .sample_rate_i (out_o.payload.sample_rate),
  .last_sample_i (out_o.payload.last_sample)
);

`default_nettype wire

// ===== tb/wcp_checker.sv =====
`default_nettype none

// Watches both channels of the WAVE chunk parser, predicts the result of each
// byte transfer and compares every result transfer against the oldest prediction.
module wcp_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wcp_in_if         in_mon,
  wcp_out_if        out_mon,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state as the block should hold it
  wcp_pkg::phase_e parse_ph;
  logic [31:0]     byte_pos;
  logic [31:0]     tag_sr;
  logic [31:0]     chunk_len;
  logic            fmt_seen;
  logic [15:0]     channels;
  logic [15:0]     align;
  logic [31:0]     rate;
  logic [7:0]      low_b;

  // Results still owed by the block, oldest first
  wcp_pkg::out_item_t result_q[$];
  wcp_pkg::out_item_t want;
  wcp_pkg::out_item_t seen;

  task automatic clear_parser();
    parse_ph  = wcp_pkg::PH_FILE;
    byte_pos  = '0;
    tag_sr    = '0;
    chunk_len = '0;
    fmt_seen  = 1'b0;
    channels  = '0;
    align     = '0;
    rate      = '0;
    low_b     = '0;
  endtask

  // Advance the parser by one byte, queue the result it causes, if any
  task automatic parse_byte(input logic [7:0] b, input logic eof);
    wcp_pkg::out_item_t res;
    logic               hit;
    wcp_pkg::err_code_e err;
    logic [31:0]        even_len;
    res      = '0;
    hit      = 1'b0;
    err      = wcp_pkg::ERR_NONE;
    even_len = {chunk_len[31:1], 1'b0};

    case (parse_ph)
      // RIFF tag, ignored file size, WAVE tag
      wcp_pkg::PH_FILE: begin
        tag_sr = {tag_sr[23:0], b};
        if (byte_pos == 32'd3 && tag_sr != wcp_pkg::TAG_RIFF) begin
          err = wcp_pkg::ERR_NOT_RIFF;
        end else if (byte_pos == 32'd11) begin
          if (eof) begin
            err = wcp_pkg::ERR_NOT_RIFF;
          end else if (tag_sr != wcp_pkg::TAG_WAVE) begin
            err = wcp_pkg::ERR_NOT_WAVE;
          end else begin
            parse_ph  = wcp_pkg::PH_HEAD;
            byte_pos  = '0;
            chunk_len = '0;
          end
        end else begin
          byte_pos++;
          if (eof) err = wcp_pkg::ERR_NOT_RIFF;
        end
      end

      // 8-byte chunk header: tag then little-endian length
      wcp_pkg::PH_HEAD: begin
        if (byte_pos < 32'd4) begin
          tag_sr = {tag_sr[23:0], b};
          if (byte_pos == 32'd0) chunk_len = '0;
        end else begin
          chunk_len = chunk_len | ({24'd0, b} << {byte_pos[1:0], 3'b000});
        end
        if (byte_pos < 32'd7) begin
          byte_pos++;
          if (eof) err = wcp_pkg::ERR_MISSING;
        end else if (tag_sr == wcp_pkg::TAG_FMT && !fmt_seen) begin
          if (chunk_len < wcp_pkg::FMT_BYTES || eof) begin
            err = wcp_pkg::ERR_FMT_SHORT;
          end else begin
            parse_ph = wcp_pkg::PH_FMT;
            byte_pos = '0;
          end
        end else if (tag_sr == wcp_pkg::TAG_DATA && fmt_seen) begin
          byte_pos = '0;
          parse_ph = (chunk_len == 32'd0) ? wcp_pkg::PH_IDLE : wcp_pkg::PH_DATA;
        end else if (chunk_len > wcp_pkg::SIZE_LIMIT) begin
          err = wcp_pkg::ERR_SIZE;
        end else if (eof) begin
          err = wcp_pkg::ERR_MISSING;
        end else begin
          byte_pos = '0;
          parse_ph = (chunk_len == 32'd0) ? wcp_pkg::PH_HEAD : wcp_pkg::PH_SKIP;
        end
      end

      wcp_pkg::PH_SKIP: begin
        byte_pos++;
        if (byte_pos >= chunk_len) begin
          parse_ph = wcp_pkg::PH_HEAD;
          byte_pos = '0;
        end
        if (eof) err = wcp_pkg::ERR_MISSING;
      end

      // First 14 bytes of fmt; the rest of the chunk is skipped
      wcp_pkg::PH_FMT: begin
        case (byte_pos)
          32'd2:  channels = {8'd0, b};
          32'd3:  channels = channels | {b, 8'd0};
          32'd4:  rate = {24'd0, b};
          32'd5:  rate = rate | {16'd0, b, 8'd0};
          32'd6:  rate = rate | {8'd0, b, 16'd0};
          32'd7:  rate = rate | {b, 24'd0};
          32'd12: align = {8'd0, b};
          32'd13: align = align | {b, 8'd0};
          default: ;
        endcase
        if (byte_pos < wcp_pkg::FMT_BYTES - 32'd1) begin
          byte_pos++;
          if (eof) err = wcp_pkg::ERR_FMT_SHORT;
        end else if (channels != 16'd1 || align != 16'd2) begin
          err = wcp_pkg::ERR_UNSUPPORTED;
        end else begin
          fmt_seen  = 1'b1;
          chunk_len = chunk_len - wcp_pkg::FMT_BYTES;
          if (eof) begin
            err = wcp_pkg::ERR_MISSING;
          end else begin
            byte_pos = '0;
            parse_ph = (chunk_len == 32'd0) ? wcp_pkg::PH_HEAD : wcp_pkg::PH_SKIP;
          end
        end
      end

      // Little-endian 16-bit samples; an unpaired last byte gives nothing
      wcp_pkg::PH_DATA: begin
        if (!byte_pos[0]) begin
          low_b = b;
        end else if (byte_pos < even_len) begin
          hit             = 1'b1;
          res.sample      = {b, low_b};
          res.sample_rate = rate;
          res.last_sample = (byte_pos == even_len - 32'd1);
        end
        byte_pos++;
        if (byte_pos >= chunk_len) parse_ph = wcp_pkg::PH_IDLE;
      end

      default: ;
    endcase

    if (err != wcp_pkg::ERR_NONE) begin
      hit            = 1'b1;
      res.is_error   = 1'b1;
      res.error_code = err;
      parse_ph       = wcp_pkg::PH_IDLE;
    end
    if (hit) result_q.push_back(res);
    if (eof) clear_parser();
  endtask

  // Compare results first: a byte's result is registered before it shows
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      result_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen = out_mon.payload;
        if (result_q.size() == 0) begin
          $error("unexpected result transfer: %p", seen);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (seen.is_error !== want.is_error) begin
            $error("is_error: expected %0b, got %0b", want.is_error, seen.is_error);
            fail_count_o++;
          end
          if (seen.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, seen.error_code);
            fail_count_o++;
          end
          if (seen.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, seen.sample);
            fail_count_o++;
          end
          if (seen.sample_rate !== want.sample_rate) begin
            $error("sample_rate: expected %0h, got %0h", want.sample_rate, seen.sample_rate);
            fail_count_o++;
          end
          if (seen.last_sample !== want.last_sample) begin
            $error("last_sample: expected %0b, got %0b", want.last_sample, seen.last_sample);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        parse_byte(in_mon.payload.file_byte, in_mon.payload.end_of_file);
      end
      pending_o = result_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_wave_chunk_parser_core.sv =====
`default_nettype none

module tb_wave_chunk_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  // No transfer for this long means the block is stuck; the longest quiet
  // stretch of a correct run is the receiver hold-off plus a few gaps.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef enum int {
    FLT_NONE,
    FLT_RIFF,
    FLT_WAVE,
    FLT_FMT_LEN,
    FLT_CHANNELS,
    FLT_ALIGN,
    FLT_BIG,
    FLT_CUT,
    FLT_NO_FMT
  } fault_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  wcp_in_if  in_if ();
  wcp_out_if out_if ();

  int         fail_count;
  int         pending;
  int         idle_pct   = 0;
  int         stall_pct  = 0;
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  bit         hold_tog   = 1'b0;
  logic [7:0] file_q[$];

  wave_chunk_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  wcp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    bit hold_ack;
    hold_left    = 0;
    hold_ack     = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_ack != hold_tog) begin
        hold_ack  = hold_tog;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Byte values leaning toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_tag(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
  endtask

  task automatic add_le(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(w[8*i +: 8]);
  endtask

  task automatic add_fill(input int n);
    for (int i = 0; i < n; i++) file_q.push_back(pick_byte());
  endtask

  // One WAV file into file_q; data_len < 0 picks a random data length
  task automatic build_file(input bit clean, input int data_len);
    fault_e      flt;
    int          len;
    logic [31:0] w;
    file_q.delete();
    if (clean || $urandom_range(0, 99) < 45) flt = FLT_NONE;
    else flt = fault_e'($urandom_range(int'(FLT_RIFF), int'(FLT_NO_FMT)));

    // file header
    add_tag(flt == FLT_RIFF ? wcp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31))
                            : wcp_pkg::TAG_RIFF);
    add_le($urandom, 4);
    add_tag(flt == FLT_WAVE ? wcp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(0, 31))
                            : wcp_pkg::TAG_WAVE);

    // unmatched chunks; a data chunk here comes before fmt and is skipped
    repeat ($urandom_range(0, 2)) begin
      add_tag($urandom_range(0, 3) == 0 ? wcp_pkg::TAG_DATA : 32'($urandom));
      len = $urandom_range(0, 5);
      add_le(len, 4);
      add_fill(len);
    end

    if (flt == FLT_BIG) begin
      case ($urandom_range(0, 3))
        0:       w = 32'h8000_0000;
        1:       w = 32'hffff_ffff;
        2:       w = 32'h8000_0000 | $urandom;
        default: w = wcp_pkg::SIZE_LIMIT;
      endcase
      add_tag($urandom);
      add_le(w, 4);
      add_fill($urandom_range(0, 4));
    end

    if (flt != FLT_NO_FMT) begin
      len = (flt == FLT_FMT_LEN) ? $urandom_range(0, 13) : 14 + $urandom_range(0, 3);
      add_tag(wcp_pkg::TAG_FMT);
      add_le(len, 4);
      add_le($urandom, 2);
      w = 32'd1;
      if (flt == FLT_CHANNELS) begin
        w = $urandom_range(0, 65535);
        if (w == 32'd1) w = 32'd0;
      end
      add_le(w, 2);
      case ($urandom_range(0, 5))
        0:       w = 32'h0000_0000;
        1:       w = 32'hffff_ffff;
        default: w = $urandom;
      endcase
      add_le(w, 4);
      add_le($urandom, 4);
      w = 32'd2;
      if (flt == FLT_ALIGN) begin
        w = $urandom_range(0, 65535);
        if (w == 32'd2) w = 32'd3;
      end
      add_le(w, 2);
      if (len > 14) add_fill(len - 14);

      // a second fmt chunk is only skipped
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(0, 6);
        add_tag(wcp_pkg::TAG_FMT);
        add_le(len, 4);
        add_fill(len);
      end
    end

    len = (data_len >= 0) ? data_len : $urandom_range(0, 25);
    add_tag(wcp_pkg::TAG_DATA);
    add_le(len, 4);
    add_fill(len);
    add_fill($urandom_range(0, 3));

    if (flt == FLT_CUT) begin
      len = $urandom_range(1, file_q.size());
      while (file_q.size() > len) void'(file_q.pop_back());
    end
  endtask

  // Offer one byte, called and returning at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= {b, eof};
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_q[i]) push_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // Sender goes quiet until every predicted result has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // bad RIFF tag, file ends on the tag's last byte
    file_q.delete();
    add_tag(wcp_pkg::TAG_RIFF ^ 32'h0000_001e);
    send_file();
    // good header but the file ends on byte 11
    file_q.delete();
    add_tag(wcp_pkg::TAG_RIFF);
    add_le(32'h0, 4);
    add_tag(wcp_pkg::TAG_WAVE);
    send_file();
    // bad WAVE tag, trailing byte ignored
    file_q.delete();
    add_tag(wcp_pkg::TAG_RIFF);
    add_le(32'hffff_ffff, 4);
    add_tag(wcp_pkg::TAG_WAVE ^ 32'h0000_0003);
    add_fill(1);
    send_file();
    drain();

    // random files across idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 58; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while a long data chunk streams in
        hold_tog = ~hold_tog;
        build_file(1'b1, 40);
        send_file();
      end
      while (bytes_sent < 30 + 175 * (ph + 1)) begin
        build_file(1'b0, -1);
        send_file();
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/wcp_pkg.sv
rtl/core/wcp_if.sv
rtl/core/wave_chunk_parser_core.sv
rtl/core/wcp_checker.sv
tb/wcp_checker.sv
tb/tb_wave_chunk_parser_core.sv
